// ===== src/msd_pkg.sv =====
// shared types, constants and tag lookups for the mjpeg stream deframer
package msd_pkg;

    localparam int HEADER_BYTES_DEF = 50;
    localparam int SIZE_BITS_DEF    = 24;

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] LINE_FEED   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [POS_W-1:0] FIXED_TAG_LEN  = 6'd5;
    localparam logic [POS_W-1:0] NUM_FIRST_POS  = 6'd5;
    localparam logic [POS_W-1:0] NUM_LAST_POS   = 6'd12;
    localparam logic [POS_W-1:0] LENGTH_TAG_LEN = 6'd15;
    localparam logic [POS_W-1:0] LENGTH_NUM_POS = 6'd16;

    typedef enum logic [5:0] {
        PH_FIXED     = 6'b000001,
        PH_FIRSTLINE = 6'b000010,
        PH_LINE      = 6'b000100,
        PH_SKIP      = 6'b001000,
        PH_DATA      = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_MULTI   = 2'd0,
        KIND_FIXED   = 2'd1,
        KIND_UNKNOWN = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STG_NONE   = 3'b001,
        STG_DIGITS = 3'b010,
        STG_AFTER  = 3'b100
    } t_stage;

    // "mjpeg"
    function automatic logic [7:0] fixed_tag(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6D;
            3'd1:    ch = 8'h6A;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h67;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "Content-Length:"
    function automatic logic [7:0] length_tag(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/mjpeg_stream_deframer_top.sv =====
// mjpeg stream deframer: header parsing, payload pass-through and frame counting
//
// Usage: the http body enters one byte per transfer on the input channel
// (i_valid / o_stall, fields i_stream_byte and i_restart). Payload bytes leave
// on the output channel (o_valid / i_stall) with frame_end, frame_number and
// stream_kind. Header bytes produce no output transfer.
// The first header picks the stream kind: a "mjpeg" prefix means fixed-size
// headers of HEADER_BYTES bytes, anything else means multipart lines with a
// "Content-Length:" line. After max_frames frames all bytes are dropped until
// a byte arrives with i_restart set.
// A payload byte appears on o_valid in the cycle after its transfer.
// Throughput: one byte per cycle while o_stall is low, set by the single
// parse stage feeding the output register; parse state updates per transfer.
// Stall: while a result sits in the output register and i_stall is high,
// o_stall is raised and no input is taken; otherwise input flows freely.
// Reset: synchronous, active low; parser to stream-kind detection, max_frames
// to 1. User must write max_frames (i_cfg_we) only while idle; not enforced.
module mjpeg_stream_deframer_top #(
    parameter int HEADER_BYTES = msd_pkg::HEADER_BYTES_DEF,
    parameter int SIZE_BITS    = msd_pkg::SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_end,
    output logic [7:0] o_frame_number,
    output logic       o_stream_kind
);
    import msd_pkg::*;

    localparam int PROD_W = SIZE_BITS + 4;
    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);

    // parser state
    t_phase                 r_phase,  n_phase;
    t_kind                  r_kind,   n_kind;
    logic [POS_W-1:0]       r_pos,    n_pos;
    logic                   r_prefix, n_prefix;
    logic [SIZE_BITS-1:0]   r_acc,    n_acc;
    logic [SIZE_BITS-1:0]   r_left,   n_left;
    logic [7:0]             r_frames, n_frames;
    logic                   r_bad,    n_bad;
    t_stage                 r_stage,  n_stage;
    logic [7:0]             r_max_frames;

    // output register
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_end;
    logic [7:0]             r_out_frame;
    logic                   r_out_kind;

    logic                   w_in_xfer;
    logic                   w_emit;
    logic                   w_end;
    logic                   w_is_digit;
    logic                   w_is_blank;
    logic [SIZE_BITS-1:0]   w_acc_base;
    logic [PROD_W-1:0]      w_prod;
    logic                   w_over;
    logic [SIZE_BITS-1:0]   w_left_dec;
    logic [7:0]             w_frames_inc;
    logic                   w_ok;

    assign o_stall   = r_out_valid && i_stall;
    assign w_in_xfer = i_valid && !o_stall;

    assign w_is_digit = (i_stream_byte >= CHAR_ZERO) && (i_stream_byte <= CHAR_NINE);
    assign w_is_blank = (i_stream_byte == CHAR_SPACE) || (i_stream_byte == CHAR_TAB) ||
                        (i_stream_byte == CHAR_CR);

    // acc * 10 + digit, seen from the state after an optional restart
    assign w_acc_base = i_restart ? '0 : r_acc;
    assign w_prod = {1'b0, w_acc_base, 3'b000} + {3'b000, w_acc_base, 1'b0}
                  + {{(PROD_W-4){1'b0}}, i_stream_byte[3:0]};
    assign w_over = |w_prod[PROD_W-1:SIZE_BITS];

    assign w_left_dec   = r_left - 1'b1;
    assign w_frames_inc = r_frames + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_pos    = r_pos;
        n_prefix = r_prefix;
        n_acc    = r_acc;
        n_left   = r_left;
        n_frames = r_frames;
        n_bad    = r_bad;
        n_stage  = r_stage;
        w_emit   = 1'b0;
        w_end    = 1'b0;
        w_ok     = 1'b0;

        if (i_restart) begin
            n_phase  = PH_FIXED;
            n_kind   = KIND_UNKNOWN;
            n_left   = '0;
            n_frames = '0;
            n_pos    = '0;
            n_prefix = 1'b1;
            n_acc    = '0;
            n_bad    = 1'b0;
            n_stage  = STG_NONE;
        end

        unique case (n_phase)
            PH_FIXED: begin
                if (n_pos < FIXED_TAG_LEN && i_stream_byte != fixed_tag(n_pos[2:0])) begin
                    n_prefix = 1'b0;
                end
                if (n_kind == KIND_UNKNOWN && !n_prefix) begin
                    // first line of a multipart stream
                    if (i_stream_byte == LINE_FEED || n_pos >= HDR_LAST) begin
                        n_kind   = KIND_MULTI;
                        n_phase  = PH_LINE;
                        n_pos    = '0;
                        n_prefix = 1'b1;
                        n_acc    = '0;
                        n_bad    = 1'b0;
                        n_stage  = STG_NONE;
                    end else begin
                        n_phase = PH_FIRSTLINE;
                        if (n_pos < POS_MAX) n_pos = n_pos + 1'b1;
                    end
                end else begin
                    if (n_pos >= NUM_FIRST_POS && n_pos <= NUM_LAST_POS) begin
                        if (!w_is_digit) begin
                            n_bad = 1'b1;
                        end else if (!n_bad) begin
                            if (w_over) n_bad = 1'b1;
                            else        n_acc = w_prod[SIZE_BITS-1:0];
                        end
                    end
                    if (n_pos >= HDR_LAST) begin
                        w_ok     = n_prefix && !n_bad && (n_acc != '0);
                        n_kind   = KIND_FIXED;
                        if (w_ok) begin
                            n_left  = n_acc;
                            n_phase = PH_DATA;
                        end
                        n_pos    = '0;
                        n_prefix = 1'b1;
                        n_acc    = '0;
                        n_bad    = 1'b0;
                        n_stage  = STG_NONE;
                    end else if (n_pos < POS_MAX) begin
                        n_pos = n_pos + 1'b1;
                    end
                end
            end
            PH_FIRSTLINE: begin
                if (i_stream_byte == LINE_FEED || n_pos >= HDR_LAST) begin
                    n_kind   = KIND_MULTI;
                    n_phase  = PH_LINE;
                    n_pos    = '0;
                    n_prefix = 1'b1;
                    n_acc    = '0;
                    n_bad    = 1'b0;
                    n_stage  = STG_NONE;
                end else if (n_pos < POS_MAX) begin
                    n_pos = n_pos + 1'b1;
                end
            end
            PH_LINE: begin
                if (n_pos < LENGTH_TAG_LEN && i_stream_byte != length_tag(n_pos[3:0])) begin
                    n_prefix = 1'b0;
                end
                if (i_stream_byte == LINE_FEED) begin
                    w_ok = n_prefix && (n_pos >= LENGTH_TAG_LEN) && !n_bad &&
                           (n_stage != STG_NONE);
                    if (w_ok) begin
                        n_left  = n_acc;
                        n_phase = PH_SKIP;
                    end
                    n_pos    = '0;
                    n_prefix = 1'b1;
                    n_acc    = '0;
                    n_bad    = 1'b0;
                    n_stage  = STG_NONE;
                end else begin
                    if (n_pos >= LENGTH_NUM_POS && n_prefix) begin
                        if (w_is_digit) begin
                            if (n_stage == STG_AFTER) begin
                                n_bad = 1'b1;
                            end else begin
                                n_stage = STG_DIGITS;
                                if (!n_bad) begin
                                    if (w_over) n_bad = 1'b1;
                                    else        n_acc = w_prod[SIZE_BITS-1:0];
                                end
                            end
                        end else if (w_is_blank) begin
                            if (n_stage == STG_DIGITS) n_stage = STG_AFTER;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    if (n_pos < POS_MAX) n_pos = n_pos + 1'b1;
                end
            end
            PH_SKIP: begin
                if (i_stream_byte == LINE_FEED) begin
                    n_pos    = '0;
                    n_prefix = 1'b1;
                    n_acc    = '0;
                    n_bad    = 1'b0;
                    n_stage  = STG_NONE;
                    // zero size: frame skipped, back to line parsing
                    n_phase  = (n_left == '0) ? PH_LINE : PH_DATA;
                end
            end
            PH_DATA: begin
                w_emit = 1'b1;
                w_end  = (w_left_dec == '0);
                n_left = w_left_dec;
                if (w_end) begin
                    n_frames = w_frames_inc;
                    n_pos    = '0;
                    n_prefix = 1'b1;
                    n_acc    = '0;
                    n_bad    = 1'b0;
                    n_stage  = STG_NONE;
                    if (w_frames_inc >= r_max_frames)  n_phase = PH_DONE;
                    else if (n_kind == KIND_FIXED)     n_phase = PH_FIXED;
                    else                               n_phase = PH_LINE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIXED;
            r_kind       <= KIND_UNKNOWN;
            r_pos        <= '0;
            r_prefix     <= 1'b1;
            r_acc        <= '0;
            r_left       <= '0;
            r_frames     <= '0;
            r_bad        <= 1'b0;
            r_stage      <= STG_NONE;
            r_max_frames <= 8'd1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_frames <= i_cfg_data;
            if (w_in_xfer) begin
                r_phase  <= n_phase;
                r_kind   <= n_kind;
                r_pos    <= n_pos;
                r_prefix <= n_prefix;
                r_acc    <= n_acc;
                r_left   <= n_left;
                r_frames <= n_frames;
                r_bad    <= n_bad;
                r_stage  <= n_stage;
            end
            if (!o_stall) r_out_valid <= w_in_xfer && w_emit;
        end
    end

    // result payload, loaded only on a payload byte transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_emit) begin
            r_out_byte  <= i_stream_byte;
            r_out_end   <= w_end;
            r_out_frame <= r_frames;
            r_out_kind  <= r_kind[0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_frame_end    = r_out_end;
    assign o_frame_number = r_out_frame;
    assign o_stream_kind  = r_out_kind;

    // a frame in progress always has bytes left
    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("payload phase with zero bytes left");

    // the kind is settled before any payload
    a_data_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_kind != KIND_UNKNOWN)
        else $error("payload phase with unknown stream kind");

    // a stopped parser passes nothing on without a restart
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_phase == PH_DONE && !i_restart) |=> !r_out_valid)
        else $error("output after frame limit reached");

endmodule
